FILE: hw/rtl/capwm_pkg.sv
package capwm_pkg;

    // Default sizes of the generator.
    localparam int NUM_CHANNELS_DEF = 3;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int DELAY_BITS_DEF   = 10;

    // Width of the channel select field of an input item.
    localparam int CHAN_BITS = 2;

    // Configuration register index width and reset values.
    localparam int          CFG_IDX_BITS      = 3;
    localparam int unsigned RESET_PERIOD      = 1000;
    localparam logic [1:0]  RESET_POLARITY    = 2'b01;
    localparam logic        RESET_IRQ_ENABLE  = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PERIOD        = 3'd0,
        CFG_RISE_DELAY    = 3'd1,
        CFG_FALL_DELAY    = 3'd2,
        CFG_POLARITY_MODE = 3'd3,
        CFG_IRQ_ENABLE    = 3'd4
    } cfg_index_t;

    // Kind of an input item.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

endpackage

FILE: hw/rtl/center_aligned_pwm_deadband_top.sv
// Data path: an accepted item passes through the input register and then the result
// register, where its result waits to be taken.
// Throughput: one item per clock when not stalled; the counter and deadband timers
// advance once per tick. Output stall backs up through the two registers; the input
// keeps flowing while the result register is free or being emptied.
// Reset (rst_n, asynchronous, active low) clears the pipeline and loads the reset state.
module center_aligned_pwm_deadband_top #(
    parameter int NUM_CHANNELS = capwm_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_BITS   = capwm_pkg::COUNT_BITS_DEF,
    parameter int DELAY_BITS   = capwm_pkg::DELAY_BITS_DEF,
    localparam int CFG_BITS    = (COUNT_BITS > DELAY_BITS) ? COUNT_BITS : DELAY_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Input item channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [capwm_pkg::CHAN_BITS-1:0]   channel,
    input  logic [COUNT_BITS-1:0]             compare_value,

    // Result item channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [NUM_CHANNELS-1:0]           pwm_a_pins,
    output logic [NUM_CHANNELS-1:0]           pwm_b_pins,
    output logic                              zero_event,
    output logic [COUNT_BITS-1:0]             count_now,
    output logic                              counting_up,

    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [capwm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]               cfg_data
);

    localparam logic [COUNT_BITS-1:0] RESET_PERIOD_C = COUNT_BITS'(capwm_pkg::RESET_PERIOD);
    localparam logic [COUNT_BITS-1:0] RESET_CMP_C    =
        COUNT_BITS'(capwm_pkg::RESET_PERIOD / 2);

    // Configuration registers. Writes are always taken.
    logic [COUNT_BITS-1:0] period_reg;
    logic [DELAY_BITS-1:0] rise_delay_reg;
    logic [DELAY_BITS-1:0] fall_delay_reg;
    logic [1:0]            polarity_reg;
    logic                  irq_enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= RESET_PERIOD_C;
            rise_delay_reg <= '0;
            fall_delay_reg <= '0;
            polarity_reg   <= capwm_pkg::RESET_POLARITY;
            irq_enable_reg <= capwm_pkg::RESET_IRQ_ENABLE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (capwm_pkg::cfg_index_t'(cfg_index))
                capwm_pkg::CFG_PERIOD:        period_reg     <= cfg_data[COUNT_BITS-1:0];
                capwm_pkg::CFG_RISE_DELAY:    rise_delay_reg <= cfg_data[DELAY_BITS-1:0];
                capwm_pkg::CFG_FALL_DELAY:    fall_delay_reg <= cfg_data[DELAY_BITS-1:0];
                capwm_pkg::CFG_POLARITY_MODE: polarity_reg   <= cfg_data[1:0];
                capwm_pkg::CFG_IRQ_ENABLE:    irq_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline control. The input register moves into the result register whenever
    // that register is empty or its item is taken in the same cycle.
    logic                            s1_valid_reg;
    logic                            s1_type_reg;
    logic [capwm_pkg::CHAN_BITS-1:0] s1_chan_reg;
    logic [COUNT_BITS-1:0]           s1_value_reg;
    logic                            out_valid_reg;
    logic                            out_load;
    logic                            in_take;

    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_take || (s1_valid_reg && !out_load);
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_type_reg  <= req_type;
            s1_chan_reg  <= channel;
            s1_value_reg <= compare_value;
        end
    end

    // Generator state.
    logic [COUNT_BITS-1:0] count_reg;
    logic                  dir_up_reg;
    logic [COUNT_BITS-1:0] shadow_reg [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] active_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] source_reg;
    logic [DELAY_BITS-1:0] rise_tmr_reg [NUM_CHANNELS];
    logic [DELAY_BITS-1:0] fall_tmr_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] dly_a_reg;
    logic [NUM_CHANNELS-1:0] dly_b_reg;

    logic [COUNT_BITS-1:0] count_next;
    logic                  dir_up_next;
    logic [COUNT_BITS-1:0] shadow_next [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] active_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] source_next;
    logic [DELAY_BITS-1:0] rise_tmr_next [NUM_CHANNELS];
    logic [DELAY_BITS-1:0] fall_tmr_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] dly_a_next;
    logic [NUM_CHANNELS-1:0] dly_b_next;

    logic [COUNT_BITS-1:0] per;
    logic                  step_up;
    logic                  at_zero;
    logic                  is_tick;

    // Timebase: count up to the period, turn, count down to zero, turn. A count left
    // above a lowered period turns and walks down from where it is.
    always_comb
    begin
        is_tick = (s1_type_reg == capwm_pkg::REQ_TICK);
        per     = (period_reg == '0) ? COUNT_BITS'(1) : period_reg;
        step_up = dir_up_reg;
        if (dir_up_reg)
        begin
            if (count_reg >= per)
            begin
                step_up    = 1'b0;
                count_next = count_reg - COUNT_BITS'(1);
            end
            else
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        else if (count_reg == '0)
        begin
            step_up    = 1'b1;
            count_next = COUNT_BITS'(1);
        end
        else
        begin
            count_next = count_reg - COUNT_BITS'(1);
        end

        if (count_next == '0)
            dir_up_next = 1'b1;
        else if (count_next >= per)
            dir_up_next = 1'b0;
        else
            dir_up_next = step_up;

        at_zero = (count_next == '0);
    end

    // Per channel: shadow load at zero, compare match, then the deadband stage.
    // The A path holds off rising edges, the B path holds off falling edges.
    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            shadow_next[i] = shadow_reg[i];
            if (int'(s1_chan_reg) == i)
                shadow_next[i] = s1_value_reg;

            active_next[i] = at_zero ? shadow_reg[i] : active_reg[i];
            source_next[i] = (count_next == active_next[i]) ? step_up : source_reg[i];

            if (source_next[i])
            begin
                dly_a_next[i]    = (rise_tmr_reg[i] >= rise_delay_reg);
                rise_tmr_next[i] = (rise_tmr_reg[i] < rise_delay_reg) ?
                                   rise_tmr_reg[i] + DELAY_BITS'(1) : rise_tmr_reg[i];
                fall_tmr_next[i] = '0;
                dly_b_next[i]    = 1'b1;
            end
            else
            begin
                dly_a_next[i]    = 1'b0;
                rise_tmr_next[i] = '0;
                dly_b_next[i]    = (fall_tmr_reg[i] < fall_delay_reg);
                fall_tmr_next[i] = (fall_tmr_reg[i] < fall_delay_reg) ?
                                   fall_tmr_reg[i] + DELAY_BITS'(1) : fall_tmr_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            dir_up_reg <= 1'b1;
            source_reg <= '0;
            dly_a_reg  <= '0;
            dly_b_reg  <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                shadow_reg[i]   <= RESET_CMP_C;
                active_reg[i]   <= RESET_CMP_C;
                rise_tmr_reg[i] <= '0;
                fall_tmr_reg[i] <= '0;
            end
        end
        else if (out_load)
        begin
            if (is_tick)
            begin
                count_reg  <= count_next;
                dir_up_reg <= dir_up_next;
                source_reg <= source_next;
                dly_a_reg  <= dly_a_next;
                dly_b_reg  <= dly_b_next;
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    active_reg[i]   <= active_next[i];
                    rise_tmr_reg[i] <= rise_tmr_next[i];
                    fall_tmr_reg[i] <= fall_tmr_next[i];
                end
            end
            else
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                    shadow_reg[i] <= shadow_next[i];
            end
        end
    end

    // Result register. A write item reports the unchanged pins, count and direction.
    logic [NUM_CHANNELS-1:0] pwm_a_reg;
    logic [NUM_CHANNELS-1:0] pwm_b_reg;
    logic                    zero_reg;
    logic [COUNT_BITS-1:0]   count_out_reg;
    logic                    up_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (is_tick)
            begin
                pwm_a_reg     <= dly_a_next ^ {NUM_CHANNELS{polarity_reg[0]}};
                pwm_b_reg     <= dly_b_next ^ {NUM_CHANNELS{polarity_reg[1]}};
                zero_reg      <= at_zero && irq_enable_reg;
                count_out_reg <= count_next;
                up_out_reg    <= dir_up_next;
            end
            else
            begin
                pwm_a_reg     <= dly_a_reg ^ {NUM_CHANNELS{polarity_reg[0]}};
                pwm_b_reg     <= dly_b_reg ^ {NUM_CHANNELS{polarity_reg[1]}};
                zero_reg      <= 1'b0;
                count_out_reg <= count_reg;
                up_out_reg    <= dir_up_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pwm_a_pins  = pwm_a_reg;
    assign pwm_b_pins  = pwm_b_reg;
    assign zero_event  = zero_reg;
    assign count_now   = count_out_reg;
    assign counting_up = up_out_reg;

endmodule

FILE: hw/rtl/capwm_checker.sv
module capwm_checker #(
    parameter int NUM_CHANNELS = capwm_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_BITS   = capwm_pkg::COUNT_BITS_DEF
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [NUM_CHANNELS-1:0] pwm_a_pins,
    input logic                    zero_event,
    input logic [COUNT_BITS-1:0]   count_now,
    input logic                    counting_up
);

    // A stalled result stays in place with its count and its A pins unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(count_now) && $stable(pwm_a_pins))
    else $error("stalled result changed");

    // The zero event is only raised on the tick that lands on zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_event |-> count_now == '0)
    else $error("zero event away from count zero");

    // At zero the counter always heads upward.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_now == '0 |-> counting_up)
    else $error("count zero while counting down");

    // A turn to counting upward happens only at or next to count zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall ##1 out_valid && counting_up && !$past(counting_up)
        |-> count_now <= COUNT_BITS'(1) || $past(count_now) == count_now
            || $past(count_now) == '0 || $past(count_now) == COUNT_BITS'(1))
    else $error("counter turned upward away from zero");

endmodule

bind center_aligned_pwm_deadband_top capwm_checker #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .COUNT_BITS(COUNT_BITS)
) u_capwm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pwm_a_pins(pwm_a_pins),
    .zero_event(zero_event),
    .count_now(count_now),
    .counting_up(counting_up)
);
